[hdl/tpas_pkg.sv]
`timescale 1ns / 1ps
// tpas_pkg: shared types and constants for the table phase accumulator synth.
// No dependencies.

package tpas_pkg;

	localparam int LEN_W    = 13;  // table_len register and effective length
	localparam int STEP_W   = 12;  // phase_step / start_phase registers
	localparam int IDX_W    = 12;  // entry_index field
	localparam int VAL_W    = 16;  // entry_value field
	localparam int OUT_PH_W = 12;  // phase_used field
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_LEN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_PHASE = 2'd2;

	// function codes of an input word; the fourth code is a no-op
	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_LOAD    = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
	} cmd_t;

	// reducer results handed to the back end
	typedef struct packed {
		logic             done;
		logic [LEN_W-1:0] step_mod;
		logic [LEN_W-1:0] phase_mod;
	} red_t;

endpackage

[hdl/table_phase_accumulator_synth_core.sv]
`timescale 1ns / 1ps
// Table phase accumulator synth core. Depends on tpas_pkg and the tpas_* modules.
// Throughput: one word per cycle while full is low; a tick word's result passes the command
// queue, the sample read register and the result queue. A write to table_len or phase_step
// starts a bit-serial remainder pass over 13 bits during which full stays high.
// Reset: phase 0, table_len 4096, phase_step 1, start_phase 0; the waveform table
// is not cleared and holds garbage until loaded.

module table_phase_accumulator_synth_core #(
	parameter int TABLE_DEPTH  = 4096,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [1:0]                       func,
	input  logic [tpas_pkg::IDX_W-1:0]       entry_index,
	input  logic [tpas_pkg::VAL_W-1:0]       entry_value,
	output logic                             empty,
	input  logic                             pop,
	output logic [SAMPLE_WIDTH-1:0]          sample,
	output logic [tpas_pkg::OUT_PH_W-1:0]    phase_used,
	input  logic                             cfg_wr_en,
	input  logic [tpas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tpas_pkg::LEN_W-1:0]       cfg_data
);

	localparam int PH_W = (TABLE_DEPTH > 4096) ? 13 : 12;
	localparam int LW   = tpas_pkg::LEN_W;
	localparam int SW   = tpas_pkg::STEP_W;
	localparam int CMD_DEPTH = 4;

	logic [LW-1:0]   table_len_q;
	logic [SW-1:0]   phase_step_q;
	logic [SW-1:0]   start_phase_q;
	logic            red_start_q;
	logic [LW-1:0]   eff_len;
	logic            red_busy;
	tpas_pkg::red_t  red;
	logic            cmd_enq;
	tpas_pkg::cmd_t  cmd_in;
	tpas_pkg::cmd_t  cmd_out;
	logic            cmd_full;
	logic            cmd_empty;
	logic            cmd_pop;
	logic [$clog2(CMD_DEPTH):0] cmd_cnt;
	logic [PH_W-1:0] phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_len_q   <= LW'(4096);
			phase_step_q  <= SW'(1);
			start_phase_q <= '0;
			red_start_q   <= 1'b0;
		end else begin
			red_start_q <= 1'b0;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					tpas_pkg::REG_TABLE_LEN: begin
						table_len_q <= cfg_data;
						red_start_q <= 1'b1;
					end
					tpas_pkg::REG_PHASE_STEP: begin
						phase_step_q <= cfg_data[SW-1:0];
						red_start_q  <= 1'b1;
					end
					tpas_pkg::REG_START_PHASE: begin
						start_phase_q <= cfg_data[SW-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// clamp length into 1..TABLE_DEPTH
	always_comb begin
		if (table_len_q == '0) begin
			eff_len = LW'(1);
		end else if (32'(table_len_q) > TABLE_DEPTH) begin
			eff_len = LW'(TABLE_DEPTH);
		end else begin
			eff_len = table_len_q;
		end
	end

	tpas_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.push        (push),
		.func        (func),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.hold        (red_busy),
		.q_full      (cmd_full),
		.full        (full),
		.enq         (cmd_enq),
		.cmd         (cmd_in)
	);

	tpas_fifo #(
		.WIDTH ($bits(tpas_pkg::cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_enq),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.full    (cmd_full),
		.empty   (cmd_empty),
		.count   (cmd_cnt)
	);

	tpas_modred #(
		.PH_W (PH_W)
	) u_modred (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start_q),
		.len    (eff_len),
		.step   (phase_step_q),
		.phase  (phase),
		.busy   (red_busy),
		.res    (red)
	);

	tpas_back #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.PH_W         (PH_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (!cmd_empty),
		.cmd         (cmd_out),
		.cmd_pop     (cmd_pop),
		.len         (eff_len),
		.start_phase (start_phase_q),
		.red         (red),
		.phase       (phase),
		.pop         (pop),
		.empty       (empty),
		.sample      (sample),
		.phase_used  (phase_used)
	);

	// front never enqueues into a full command queue
	a_no_cmd_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_enq |-> !cmd_full)
		else $error("command queue written while full");

	// command queue occupancy stays within its depth
	a_cmd_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cmd_cnt) <= CMD_DEPTH)
		else $error("command queue count out of range");

	// a finished reduction yields a step below the length it was computed for
	a_step_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(red.done && !red_start_q) |-> (red.step_mod < eff_len))
		else $error("reduced step not below table length");

	// a configuration write that needs a reduction blocks input in the next cycle
	a_hold_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr_en && (cfg_index == tpas_pkg::REG_TABLE_LEN
			|| cfg_index == tpas_pkg::REG_PHASE_STEP)) |=> full)
		else $error("input not held during reduction");

endmodule

[hdl/tpas_fifo.sv]
`timescale 1ns / 1ps
// tpas_fifo: small register-based FIFO with occupancy count.
// Stand-alone; used for the command queue and the result queue.

module tpas_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH):0]     count
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_ptr_q;
	logic [AW:0]      rd_ptr_q;
	logic             do_wr;
	logic             do_rd;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]) && (wr_ptr_q[AW] != rd_ptr_q[AW]);
	assign count = wr_ptr_q - rd_ptr_q;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q[AW-1:0]] <= wr_data;
		end
	end

endmodule

[hdl/tpas_front.sv]
`timescale 1ns / 1ps
// tpas_front: accepts input words, drops no-op codes and out-of-range loads,
// and queues the rest as commands. Depends on tpas_pkg.

module tpas_front #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                       push,
	input  logic [1:0]                 func,
	input  logic [tpas_pkg::IDX_W-1:0] entry_index,
	input  logic [tpas_pkg::VAL_W-1:0] entry_value,
	input  logic                       hold,
	input  logic                       q_full,
	output logic                       full,
	output logic                       enq,
	output tpas_pkg::cmd_t             cmd
);

	logic keep;

	assign full = q_full || hold;

	always_comb begin
		cmd.idx = entry_index;
		cmd.val = entry_value;
		cmd.op  = tpas_pkg::OP_TICK;
		keep    = 1'b0;
		unique case (func)
			tpas_pkg::OP_TICK: begin
				keep = 1'b1;
			end
			tpas_pkg::OP_LOAD: begin
				cmd.op = tpas_pkg::OP_LOAD;
				keep   = (32'(entry_index) < TABLE_DEPTH);
			end
			tpas_pkg::OP_RESTART: begin
				cmd.op = tpas_pkg::OP_RESTART;
				keep   = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign enq = push && !full && keep;

endmodule

[hdl/tpas_modred.sv]
`timescale 1ns / 1ps
// tpas_modred: radix-2 restoring remainder unit, one bit per cycle.
// Reduces the step and the current phase modulo the table length. Depends on tpas_pkg.

module tpas_modred #(
	parameter int PH_W = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tpas_pkg::LEN_W-1:0]  len,
	input  logic [tpas_pkg::STEP_W-1:0] step,
	input  logic [PH_W-1:0]             phase,
	output logic                        busy,
	output tpas_pkg::red_t              res
);

	localparam int LW = tpas_pkg::LEN_W;
	localparam int CW = $clog2(LW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] dvd_s_q;
	logic [LW-1:0] dvd_p_q;
	logic [LW-1:0] rem_s_q;
	logic [LW-1:0] rem_p_q;
	logic [LW-1:0] step_mod_q;
	logic [LW-1:0] phase_mod_q;
	logic [LW-1:0] nxt_s;
	logic [LW-1:0] nxt_p;

	function automatic logic [LW-1:0] rem_bit(input logic [LW-1:0] rem, input logic b,
			input logic [LW-1:0] d);
		logic [LW:0] t;
		t = {rem, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[LW-1:0];
	endfunction

	assign nxt_s = rem_bit(rem_s_q, dvd_s_q[LW-1], len_q);
	assign nxt_p = rem_bit(rem_p_q, dvd_p_q[LW-1], len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			cnt_q      <= '0;
			step_mod_q <= LW'(1);
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(LW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q     <= 1'b0;
					done_q     <= 1'b1;
					step_mod_q <= nxt_s;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			len_q   <= len;
			dvd_s_q <= LW'(step);
			dvd_p_q <= LW'(phase);
			rem_s_q <= '0;
			rem_p_q <= '0;
		end else if (busy_q) begin
			dvd_s_q <= dvd_s_q << 1;
			dvd_p_q <= dvd_p_q << 1;
			rem_s_q <= nxt_s;
			rem_p_q <= nxt_p;
			if (cnt_q == CW'(1)) begin
				phase_mod_q <= nxt_p;
			end
		end
	end

	assign busy          = start || busy_q;
	assign res.done      = done_q;
	assign res.step_mod  = step_mod_q;
	assign res.phase_mod = phase_mod_q;

endmodule

[hdl/tpas_back.sv]
`timescale 1ns / 1ps
// tpas_back: executes queued commands: table writes, phase restart, and
// sample reads with phase advance; results go to an output queue.
// Depends on tpas_pkg and tpas_fifo.

module tpas_back #(
	parameter int TABLE_DEPTH  = 4096,
	parameter int SAMPLE_WIDTH = 16,
	parameter int PH_W         = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  tpas_pkg::cmd_t                cmd,
	output logic                          cmd_pop,
	input  logic [tpas_pkg::LEN_W-1:0]    len,
	input  logic [tpas_pkg::STEP_W-1:0]   start_phase,
	input  tpas_pkg::red_t                red,
	output logic [PH_W-1:0]               phase,
	input  logic                          pop,
	output logic                          empty,
	output logic [SAMPLE_WIDTH-1:0]       sample,
	output logic [tpas_pkg::OUT_PH_W-1:0] phase_used
);

	localparam int AW        = $clog2(TABLE_DEPTH);
	localparam int LW        = tpas_pkg::LEN_W;
	localparam int OUT_DEPTH = 4;
	localparam int OW        = SAMPLE_WIDTH + tpas_pkg::OUT_PH_W;

	logic [SAMPLE_WIDTH-1:0]   wave_q [TABLE_DEPTH];
	logic [PH_W-1:0]           phase_q;
	logic [LW-1:0]             phase_mod_q;
	logic                      tick_s1;
	logic [SAMPLE_WIDTH-1:0]   sample_s1;
	logic [PH_W-1:0]           phase_s1;
	logic [$clog2(OUT_DEPTH):0] out_cnt;
	logic                      out_full;
	logic                      credit;
	logic                      do_tick;
	logic                      do_load;
	logic                      do_restart;
	logic [LW:0]               sum;
	logic [LW-1:0]             adv;
	logic [LW-1:0]             rs_phase;
	logic [OW-1:0]             out_word;

	// room for the in-flight read plus this one
	assign credit  = (32'(out_cnt) + 32'(tick_s1)) < OUT_DEPTH;
	assign cmd_pop = cmd_valid && ((cmd.op != tpas_pkg::OP_TICK) || credit);

	assign do_tick    = cmd_pop && (cmd.op == tpas_pkg::OP_TICK);
	assign do_load    = cmd_pop && (cmd.op == tpas_pkg::OP_LOAD);
	assign do_restart = cmd_pop && (cmd.op == tpas_pkg::OP_RESTART);

	// after a finished pass both phase_mod_q and red.step_mod are below len, so one subtract wraps
	always_comb begin
		sum = {1'b0, phase_mod_q} + {1'b0, red.step_mod};
		if (sum >= {1'b0, len}) begin
			sum = sum - {1'b0, len};
		end
		adv = sum[LW-1:0];
	end

	assign rs_phase = ({1'b0, start_phase} < len) ? LW'(start_phase) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			phase_mod_q <= '0;
			tick_s1     <= 1'b0;
		end else begin
			tick_s1 <= do_tick;
			if (red.done) begin
				phase_mod_q <= red.phase_mod;
			end else if (do_restart) begin
				phase_q     <= PH_W'(rs_phase);
				phase_mod_q <= rs_phase;
			end else if (do_tick) begin
				phase_q     <= PH_W'(adv);
				phase_mod_q <= adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			wave_q[AW'(cmd.idx)] <= SAMPLE_WIDTH'(cmd.val);
		end
	end

	always_ff @(posedge clk) begin
		if (do_tick) begin
			sample_s1 <= wave_q[AW'(phase_q)];
			phase_s1  <= phase_q;
		end
	end

	assign phase    = phase_q;
	assign out_word = {sample_s1, tpas_pkg::OUT_PH_W'(phase_s1)};

	tpas_fifo #(
		.WIDTH (OW),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tick_s1),
		.wr_data (out_word),
		.rd_en   (pop),
		.rd_data ({sample, phase_used}),
		.full    (out_full),
		.empty   (empty),
		.count   (out_cnt)
	);

	// credit keeps the result queue from overflowing
	always_comb begin
		if (tick_s1 && out_full) begin
			$error("result queue overflow");
		end
	end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for table_phase_accumulator_synth_core.
// Depends on tpas_pkg and the core RTL; directed table first, then random register writes and
// load/restart/tick/no-op traffic checked against a behavioral phase accumulator.

module tb_top;

	localparam int         IDX_W     = tpas_pkg::IDX_W;
	localparam int         VAL_W     = tpas_pkg::VAL_W;
	localparam int         LEN_W     = tpas_pkg::LEN_W;
	localparam int         OUT_PH_W  = tpas_pkg::OUT_PH_W;
	localparam int         CFG_IDX_W = tpas_pkg::CFG_IDX_W;
	localparam int         DEPTH     = 4096;
	localparam int         DRAIN_GAP = 20;   // covers result latency and the remainder pass
	localparam int         SEG_WORDS = 54;
	localparam int         DIR_ROWS  = 30;
	localparam logic [1:0] FUNC_NOP  = 2'd3;
	localparam logic       ROW_ITEM  = 1'b0;
	localparam logic       ROW_CFG   = 1'b1;

	typedef struct packed {
		logic [VAL_W-1:0]    sample;
		logic [OUT_PH_W-1:0] phase;
	} synth_word_t;

	typedef struct packed {
		logic             is_cfg;
		logic [1:0]       code;   // func for a word, register index for a write
		logic [LEN_W-1:0] arg;    // entry_index or register data
		logic [VAL_W-1:0] val;
		logic             typed;
		synth_word_t      want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [1:0]           func;
	logic [IDX_W-1:0]     entry_index;
	logic [VAL_W-1:0]     entry_value;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [VAL_W-1:0]     sample;
	logic [OUT_PH_W-1:0]  phase_used;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0]     cfg_data;

	// behavioral copy of the synth state
	logic [VAL_W-1:0]    wave [DEPTH];
	bit                  loaded [DEPTH];
	logic [OUT_PH_W-1:0] cur_phase;
	logic [LEN_W-1:0]    len_reg;
	logic [11:0]         step_reg;
	logic [11:0]         start_reg;

	synth_word_t word_q [$];
	int          err_count = 0;
	int          tx_idle;
	int          rx_idle;

	// length starts at its reset of 4096, step 1, start phase 0
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_ITEM, tpas_pkg::OP_LOAD,    13'd0,    16'hFFFF, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_LOAD,    13'd1,    16'h0000, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_LOAD,    13'd4095, 16'hA5A5, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_TICK,    13'd0,    16'h0000, 1'b1, '{16'hFFFF, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_TICK,    13'd4095, 16'hFFFF, 1'b1, '{16'h0000, 12'd1}},
		'{ROW_ITEM, FUNC_NOP,             13'd4095, 16'hFFFF, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_CFG,  tpas_pkg::REG_START_PHASE, 13'd4095, 16'h0000, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_RESTART, 13'd0,    16'h0000, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_TICK,    13'd0,    16'h0000, 1'b1, '{16'hA5A5, 12'd4095}},
		'{ROW_ITEM, tpas_pkg::OP_TICK,    13'd0,    16'h0000, 1'b1, '{16'hFFFF, 12'd0}},
		// zero length acts as one; phase 1 now sits past the end
		'{ROW_CFG,  tpas_pkg::REG_TABLE_LEN,  13'd0,    16'h0000, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_CFG,  tpas_pkg::REG_PHASE_STEP, 13'd4095, 16'h0000, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_TICK,    13'd0,    16'h0000, 1'b1, '{16'h0000, 12'd1}},
		'{ROW_ITEM, tpas_pkg::OP_TICK,    13'd0,    16'h0000, 1'b1, '{16'hFFFF, 12'd0}},
		// start phase out of range restarts at zero
		'{ROW_ITEM, tpas_pkg::OP_RESTART, 13'd0,    16'h0000, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_TICK,    13'd0,    16'h0000, 1'b1, '{16'hFFFF, 12'd0}},
		// length above depth clamps to 4096
		'{ROW_CFG,  tpas_pkg::REG_TABLE_LEN,  13'd8191, 16'h0000, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_RESTART, 13'd0,    16'h0000, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_LOAD,    13'd4094, 16'h8001, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_TICK,    13'd0,    16'h0000, 1'b1, '{16'hA5A5, 12'd4095}},
		'{ROW_ITEM, tpas_pkg::OP_TICK,    13'd0,    16'h0000, 1'b1, '{16'h8001, 12'd4094}},
		// step 7 over length 3 reduces to 1
		'{ROW_CFG,  tpas_pkg::REG_TABLE_LEN,   13'd3, 16'h0000, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_CFG,  tpas_pkg::REG_PHASE_STEP,  13'd7, 16'h0000, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_CFG,  tpas_pkg::REG_START_PHASE, 13'd2, 16'h0000, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_LOAD,    13'd2,    16'h7FFE, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_RESTART, 13'd0,    16'h0000, 1'b0, '{16'h0000, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_TICK,    13'd0,    16'h0000, 1'b1, '{16'h7FFE, 12'd2}},
		'{ROW_ITEM, tpas_pkg::OP_TICK,    13'd0,    16'h0000, 1'b1, '{16'hFFFF, 12'd0}},
		'{ROW_ITEM, tpas_pkg::OP_TICK,    13'd0,    16'h0000, 1'b1, '{16'h0000, 12'd1}},
		'{ROW_ITEM, tpas_pkg::OP_TICK,    13'd0,    16'h0000, 1'b0, '{16'h0000, 12'd0}}
	};

	table_phase_accumulator_synth_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.func        (func),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.empty       (empty),
		.pop         (pop),
		.sample      (sample),
		.phase_used  (phase_used),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int active_len();
		if (len_reg == '0)
			return 1;
		if (len_reg > DEPTH)
			return DEPTH;
		return int'(len_reg);
	endfunction

	task automatic synth_step(input logic [1:0] f, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val, output bit got, output synth_word_t res);
		int span;
		span = active_len();
		got  = 1'b0;
		res  = '0;
		case (f)
			tpas_pkg::OP_LOAD: begin
				wave[idx]   = val;
				loaded[idx] = 1'b1;
			end
			tpas_pkg::OP_RESTART: cur_phase = (int'(start_reg) < span) ? start_reg : '0;
			tpas_pkg::OP_TICK: begin
				res.sample = wave[cur_phase];
				res.phase  = cur_phase;
				got        = 1'b1;
				cur_phase  = 12'((int'(cur_phase) + int'(step_reg) % span) % span);
			end
			default: ;
		endcase
	endtask

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		err_count++;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(input logic [1:0] f, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val, input bit typed, input synth_word_t want);
		bit          got;
		synth_word_t res;
		while ($urandom_range(0, 99) < tx_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push        <= 1'b1;
		func        <= f;
		entry_index <= idx;
		entry_value <= val;
		do @(posedge clk); while (full);
		synth_step(f, idx, val, got, res);
		if (got)
			word_q.push_back(typed ? want : res);
		@(negedge clk);
	endtask

	// always waits for a falling edge, then goes on until no word is still expected
	task automatic wait_drained();
		push <= 1'b0;
		do @(negedge clk); while (word_q.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input logic [LEN_W-1:0] d);
		wait_drained();
		repeat (DRAIN_GAP) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (r)
			tpas_pkg::REG_TABLE_LEN:   len_reg   = d;
			tpas_pkg::REG_PHASE_STEP:  step_reg  = d[11:0];
			tpas_pkg::REG_START_PHASE: start_reg = d[11:0];
			default: ;
		endcase
	endtask

	always @(negedge clk)
		pop <= ($urandom_range(0, 99) >= rx_idle);

	always @(posedge clk) begin : check_words
		synth_word_t want;
		if (arst_n && pop && !empty) begin
			if (word_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected word sample %h phase %0d",
					sample, phase_used));
			end else begin
				want = word_q.pop_front();
				if (sample !== want.sample)
					flag_mismatch($sformatf("sample %h, wanted %h (phase %0d)",
						sample, want.sample, want.phase));
				if (phase_used !== want.phase)
					flag_mismatch($sformatf("phase_used %0d, wanted %0d",
						phase_used, want.phase));
			end
		end
	end

	initial begin
		int m;
		int seg;
		int words;
		int roll;
		int d;
		arst_n      = 1'b0;
		push        = 1'b0;
		func        = tpas_pkg::OP_TICK;
		entry_index = '0;
		entry_value = '0;
		cfg_wr_en   = 1'b0;
		cfg_index   = tpas_pkg::REG_TABLE_LEN;
		cfg_data    = '0;
		cur_phase   = '0;
		len_reg     = 13'd4096;
		step_reg    = 12'd1;
		start_reg   = '0;
		for (int i = 0; i < DEPTH; i++)
			loaded[i] = 1'b0;
		tx_idle = 26;
		rx_idle = 50;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].is_cfg)
				write_reg(dir_rows[i].code, dir_rows[i].arg);
			else
				send_word(dir_rows[i].code, dir_rows[i].arg[IDX_W-1:0], dir_rows[i].val,
					dir_rows[i].typed, dir_rows[i].want);
		end

		for (m = 0; m < 3; m++) begin
			tx_idle = (m == 0) ? 26 : (m == 1) ? 50 : 0;
			rx_idle = (m == 0) ? 50 : (m == 1) ? 26 : 0;
			for (seg = 0; seg < 4; seg++) begin
				if ($urandom_range(0, 9) < 7) begin
					case ($urandom_range(0, 9))
						0: d = 0;
						1: d = 4096;
						2: d = 8191;
						3: d = $urandom_range(4097, 8191);
						4: d = $urandom_range(1, 4096);
						default: d = $urandom_range(1, 12);
					endcase
					write_reg(tpas_pkg::REG_TABLE_LEN, d[LEN_W-1:0]);
				end
				if ($urandom_range(0, 9) < 7) begin
					case ($urandom_range(0, 5))
						0: d = 0;
						1: d = 4095;
						2: d = $urandom_range(0, 4095);
						default: d = $urandom_range(0, 20);
					endcase
					write_reg(tpas_pkg::REG_PHASE_STEP, d[LEN_W-1:0]);
				end
				if ($urandom_range(0, 9) < 7) begin
					case ($urandom_range(0, 4))
						0: d = 0;
						1: d = 4095;
						2: d = $urandom_range(0, 4095);
						default: d = $urandom_range(0, 15);
					endcase
					write_reg(tpas_pkg::REG_START_PHASE, d[LEN_W-1:0]);
				end
				words = 0;
				while (words < SEG_WORDS) begin
					roll = $urandom_range(0, 99);
					if (roll < 20) begin
						// mostly inside the active length so ticks find loaded entries
						if ($urandom_range(0, 3) != 0)
							d = $urandom_range(0, active_len() - 1);
						else
							d = $urandom_range(0, DEPTH - 1);
						send_word(tpas_pkg::OP_LOAD, d[IDX_W-1:0],
							16'($urandom_range(0, 65535)), 1'b0, '0);
						words++;
					end else if (roll < 32) begin
						send_word(tpas_pkg::OP_RESTART, 12'($urandom_range(0, 4095)),
							16'($urandom_range(0, 65535)), 1'b0, '0);
						words++;
					end else if (roll < 37) begin
						send_word(FUNC_NOP, 12'($urandom_range(0, 4095)),
							16'($urandom_range(0, 65535)), 1'b0, '0);
					end else if (roll < 39) begin
						wait_drained();
					end else begin
						// never tick onto an entry that was not loaded
						if (!loaded[cur_phase]) begin
							send_word(tpas_pkg::OP_LOAD, cur_phase,
								16'($urandom_range(0, 65535)), 1'b0, '0);
							words++;
						end
						send_word(tpas_pkg::OP_TICK, 12'($urandom_range(0, 4095)),
							16'($urandom_range(0, 65535)), 1'b0, '0);
						words++;
					end
				end
			end
		end

		wait_drained();
		repeat (DRAIN_GAP) @(negedge clk);
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule

[files.f]
hdl/tpas_pkg.sv
hdl/tpas_fifo.sv
hdl/tpas_front.sv
hdl/tpas_modred.sv
hdl/tpas_back.sv
hdl/table_phase_accumulator_synth_core.sv
test/tb_top.sv
